/* rtl/core/gkirf_pkg.sv */
`default_nettype none

package gkirf_pkg;

    // field widths
    localparam int CMD_W   = 1;
    localparam int SLOT_W  = 2;
    localparam int HALF_W  = 64;
    localparam int KEY_W   = 128;
    localparam int CTR_W   = 48;
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSTALL = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RECORD  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_INSTALLED = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RECORDED  = 2'd2;

    // key table write request
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } t_key_wr;

    // finished result from the sequencer
    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic              carried;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/gkirf_ram.sv */
`default_nettype none

module gkirf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/gkirf_keytab.sv */
`default_nettype none

module gkirf_keytab #(
    parameter int KEY_SLOTS = 4,
    parameter int SW        = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire gkirf_pkg::t_key_wr        i_wr,
    input  wire logic [gkirf_pkg::KEY_W-1:0] i_cmp_key,
    output logic      [KEY_SLOTS-1:0]      o_match
);

    logic [gkirf_pkg::KEY_W-1:0] r_key [KEY_SLOTS];
    logic [KEY_SLOTS-1:0]        r_inst;

    // install marks clear on reset; keys hold until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inst <= '0;
        end else if (i_wr.en) begin
            r_inst[i_wr.slot[SW-1:0]] <= 1'b1;
        end
        if (i_wr.en) begin
            r_key[i_wr.slot[SW-1:0]] <= i_wr.key;
        end
    end

    // flag every installed slot that holds the compared key
    always_comb begin
        for (int s = 0; s < KEY_SLOTS; s++) begin
            o_match[s] = r_inst[s] && (r_key[s] == i_cmp_key);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/gkirf_seq.sv */
`default_nettype none

module gkirf_seq #(
    parameter int KEY_SLOTS    = 4,
    parameter int REPLAY_SLOTS = 16,
    parameter int RSC_BYTES    = 6,
    parameter int SW           = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1,
    parameter int IW           = (REPLAY_SLOTS > 1) ? $clog2(REPLAY_SLOTS) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // incoming word
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [gkirf_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [gkirf_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [gkirf_pkg::KEY_W-1:0]  i_key,
    input  wire logic [gkirf_pkg::CTR_W-1:0]  i_rsc,
    input  wire logic [gkirf_pkg::IDX_W-1:0]  i_idx,
    input  wire logic [gkirf_pkg::CTR_W-1:0]  i_pn,
    // key table
    output logic      [gkirf_pkg::KEY_W-1:0]  o_cmp_key,
    input  wire logic [KEY_SLOTS-1:0]         i_match,
    output gkirf_pkg::t_key_wr                o_key_wr,
    // counter memory
    output logic                              o_we,
    output logic      [SW+IW-1:0]             o_waddr,
    output logic      [gkirf_pkg::CTR_W-1:0]  o_wdata,
    output logic      [SW+IW-1:0]             o_raddr,
    input  wire logic [gkirf_pkg::CTR_W-1:0]  i_rdata,
    // result
    input  wire logic                         i_out_free,
    output gkirf_pkg::t_result                o_result
);

    localparam int RSC_USED = (RSC_BYTES > 6) ? 6 : RSC_BYTES;
    localparam int RSC_BITS = 8 * RSC_USED;
    localparam logic [gkirf_pkg::CTR_W-1:0] RSC_MASK =
        gkirf_pkg::CTR_W'((49'd1 << RSC_BITS) - 49'd1);
    localparam logic [SW-1:0] LAST_S = SW'(KEY_SLOTS - 1);
    localparam logic [IW-1:0] LAST_I = IW'(REPLAY_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } t_state;

    t_state                          r_state;
    logic [gkirf_pkg::CMD_W-1:0]     r_cmd;
    logic [gkirf_pkg::SLOT_W-1:0]    r_slot;
    logic [gkirf_pkg::KEY_W-1:0]     r_key;
    logic [gkirf_pkg::CTR_W-1:0]     r_rsc;
    logic [gkirf_pkg::IDX_W-1:0]     r_idx;
    logic [gkirf_pkg::CTR_W-1:0]     r_pn;
    logic [KEY_SLOTS-1:0]            r_match;
    logic [gkirf_pkg::STAT_W-1:0]    r_status;
    logic                            r_carried;
    logic [SW-1:0]                   r_s;
    logic [IW-1:0]                   r_i;
    logic                            r_rd_vld;
    logic [SW-1:0]                   r_rd_s;
    logic [IW-1:0]                   r_rd_i;
    logic [gkirf_pkg::CTR_W-1:0]     r_floor;

    logic                            slot_ok;
    logic                            idx_ok;
    logic                            ignore;
    logic                            rd_last;
    logic                            hit;
    logic [gkirf_pkg::CTR_W-1:0]     cur_floor;
    logic [gkirf_pkg::CTR_W-1:0]     n_floor;

    assign slot_ok = ({1'b0, r_slot} < 3'(KEY_SLOTS));
    assign idx_ok  = ({1'b0, r_idx} < 5'(REPLAY_SLOTS));
    assign ignore  = !slot_ok || i_match[r_slot[SW-1:0]];

    assign o_ready   = (r_state == S_IDLE);
    assign o_cmp_key = r_key;
    assign o_raddr   = {r_s, r_i};

    // running maximum over the matching slots of one replay index
    assign rd_last   = (r_rd_s == LAST_S);
    assign cur_floor = (r_rd_s == '0) ? r_rsc : r_floor;
    assign hit       = r_rd_vld && r_match[r_rd_s] && (i_rdata > cur_floor);
    assign n_floor   = hit ? i_rdata : cur_floor;

    // counter memory write: record word or finished floor
    always_comb begin
        o_we    = 1'b0;
        o_waddr = {r_slot[SW-1:0], r_idx[IW-1:0]};
        o_wdata = r_pn;
        if (r_state == S_CHECK && r_cmd == gkirf_pkg::CMD_RECORD) begin
            o_we = slot_ok && idx_ok;
        end else if (r_rd_vld && rd_last) begin
            o_we    = 1'b1;
            o_waddr = {r_slot[SW-1:0], r_rd_i};
            o_wdata = n_floor;
        end
    end

    // store the key and the installed mark as the last floor is written
    always_comb begin
        o_key_wr.en   = (r_state == S_DRAIN);
        o_key_wr.slot = r_slot;
        o_key_wr.key  = r_key;
    end

    always_comb begin
        o_result.valid   = (r_state == S_RESP) && i_out_free;
        o_result.status  = r_status;
        o_result.carried = r_carried;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_cmd == gkirf_pkg::CMD_RECORD || ignore) begin
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_s == LAST_S && r_i == LAST_I) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: capture word, step the scan, hold the floor
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd     <= i_cmd;
            r_slot    <= i_slot;
            r_key     <= i_key;
            r_rsc     <= i_rsc & RSC_MASK;
            r_idx     <= i_idx;
            r_pn      <= i_pn;
            r_carried <= 1'b0;
            r_s       <= '0;
            r_i       <= '0;
        end
        if (r_state == S_CHECK) begin
            r_match <= i_match;
            if (r_cmd == gkirf_pkg::CMD_RECORD) begin
                r_status <= gkirf_pkg::ST_RECORDED;
            end else if (ignore) begin
                r_status <= gkirf_pkg::ST_IGNORED;
            end else begin
                r_status <= gkirf_pkg::ST_INSTALLED;
            end
        end
        if (r_state == S_SCAN) begin
            r_rd_s <= r_s;
            r_rd_i <= r_i;
            if (r_s == LAST_S) begin
                r_s <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_s <= r_s + 1'b1;
            end
        end
        if (r_rd_vld) begin
            r_floor   <= n_floor;
            r_carried <= r_carried | hit;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/group_key_install_replay_floor_top.sv */
`default_nettype none
// A record or an ignored install passes from the check state to the response state, and its
// result word is then registered at the output; an install that is carried out scans the
// counter memory with one read per slot and replay index, writes the floor of each replay
// index once its last slot has been read, stores the key in the drain state, then responds.
// Only one word is taken at a time; a result held at the output stalls the next.
// Reset (synchronous, active low) clears the installed marks and control state only.

module group_key_install_replay_floor_top #(
    parameter int REPLAY_SLOTS = 16,
    parameter int RSC_BYTES    = 6,
    parameter int KEY_SLOTS    = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave side
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // key_slot[1:0], key_low[65:2], key_high[129:66], rsc[177:130],
    // replay_index[181:178], packet_number[229:182], zero[231:230]
    input  wire logic [231:0] i_s_tdata,
    // cmd[0]
    input  wire logic         i_s_tuser,
    // master side
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // status[1:0], floor_carried[2], zero[7:3]
    output logic      [7:0]   o_m_tdata
);

    localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int IW = (REPLAY_SLOTS > 1) ? $clog2(REPLAY_SLOTS) : 1;
    localparam int DEPTH = KEY_SLOTS << IW;

    logic [KEY_SLOTS-1:0]          match;
    logic [gkirf_pkg::KEY_W-1:0]   cmp_key;
    gkirf_pkg::t_key_wr            key_wr;
    gkirf_pkg::t_result            result;
    logic                          we;
    logic [SW+IW-1:0]              waddr;
    logic [SW+IW-1:0]              raddr;
    logic [gkirf_pkg::CTR_W-1:0]   wdata;
    logic [gkirf_pkg::CTR_W-1:0]   rdata;
    logic                          out_free;

    logic                          r_out_valid;
    logic [gkirf_pkg::STAT_W-1:0]  r_out_status;
    logic                          r_out_carried;

    assign out_free = !r_out_valid || i_m_tready;

    gkirf_seq #(
        .KEY_SLOTS    (KEY_SLOTS),
        .REPLAY_SLOTS (REPLAY_SLOTS),
        .RSC_BYTES    (RSC_BYTES),
        .SW           (SW),
        .IW           (IW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_slot     (i_s_tdata[1:0]),
        .i_key      ({i_s_tdata[129:66], i_s_tdata[65:2]}),
        .i_rsc      (i_s_tdata[177:130]),
        .i_idx      (i_s_tdata[181:178]),
        .i_pn       (i_s_tdata[229:182]),
        .o_cmp_key  (cmp_key),
        .i_match    (match),
        .o_key_wr   (key_wr),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .i_out_free (out_free),
        .o_result   (result)
    );

    gkirf_keytab #(
        .KEY_SLOTS (KEY_SLOTS),
        .SW        (SW)
    ) u_keytab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (key_wr),
        .i_cmp_key (cmp_key),
        .o_match   (match)
    );

    gkirf_ram #(
        .WIDTH (gkirf_pkg::CTR_W),
        .DEPTH (DEPTH),
        .AW    (SW + IW)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register: hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (result.valid) begin
            r_out_status  <= result.status;
            r_out_carried <= result.carried;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_carried, r_out_status};

endmodule

`default_nettype wire
